@@ design/utf8v_pkg.sv @@
// Shared types, codes and helper functions for the UTF-8 text validator.
`default_nettype none
package utf8v_pkg;

   localparam int unsigned DataWidth = 8;

   typedef enum logic [2:0] {
      STATUS_VALID     = 3'd0,
      STATUS_ASCII     = 3'd1,
      STATUS_BAD_LEAD  = 3'd2,
      STATUS_BAD_CONT  = 3'd3,
      STATUS_TRUNCATED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FAIL_NONE = 2'd0,
      FAIL_LEAD = 2'd1,
      FAIL_CONT = 2'd2
   } fail_type;

   // Scan state carried from one byte of a string to the next.
   typedef struct packed {
      logic [2:0] pending;
      logic       all_ascii;
      fail_type   fail;
   } scan_state_type;

   localparam scan_state_type ScanReset = '{pending: 3'd0, all_ascii: 1'b1, fail: FAIL_NONE};

   typedef struct packed {
      logic       ok;
      logic [2:0] count;
   } lead_type;

   // Continuation bytes that follow a lead byte in the old 1-to-6-byte forms.
   function automatic lead_type lead_extra(input logic [DataWidth-1:0] b);
      lead_type r;
      r.ok    = 1'b1;
      r.count = 3'd0;
      priority if (b == 8'hFC || b == 8'hFD) begin
         r.count = 3'd5;
      end else if (b >= 8'hF8) begin
         r.count = 3'd4;
      end else if (b >= 8'hF0) begin
         r.count = 3'd3;
      end else if (b >= 8'hE0) begin
         r.count = 3'd2;
      end else if (b >= 8'hC0) begin
         r.count = 3'd1;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ design/utf8v_decode.sv @@
// Per-byte scan step: next scan state and the verdict for a string ending here.
`default_nettype none
module utf8v_decode (
   input  utf8v_pkg::scan_state_type         cur_state,
   input  logic [utf8v_pkg::DataWidth-1:0]   data_byte,
   output utf8v_pkg::scan_state_type         next_state,
   output utf8v_pkg::status_type             status
);

   utf8v_pkg::lead_type lead;

   always_comb begin
      lead       = utf8v_pkg::lead_extra(data_byte);
      next_state = cur_state;
      // Once a failure is recorded, the rest of the string is ignored.
      if (cur_state.fail == utf8v_pkg::FAIL_NONE) begin
         if (data_byte[7]) begin
            next_state.all_ascii = 1'b0;
         end
         if (cur_state.pending == 3'd0) begin
            if (data_byte[7]) begin
               if (!lead.ok) begin
                  next_state.fail = utf8v_pkg::FAIL_LEAD;
               end else begin
                  next_state.pending = lead.count;
               end
            end
         end else begin
            if (data_byte[7:6] != 2'b10) begin
               next_state.fail = utf8v_pkg::FAIL_CONT;
            end else begin
               next_state.pending = cur_state.pending - 3'd1;
            end
         end
      end
   end

   always_comb begin
      priority if (next_state.fail == utf8v_pkg::FAIL_LEAD) begin
         status = utf8v_pkg::STATUS_BAD_LEAD;
      end else if (next_state.fail == utf8v_pkg::FAIL_CONT) begin
         status = utf8v_pkg::STATUS_BAD_CONT;
      end else if (next_state.pending != 3'd0) begin
         status = utf8v_pkg::STATUS_TRUNCATED;
      end else if (next_state.all_ascii) begin
         status = utf8v_pkg::STATUS_ASCII;
      end else begin
         status = utf8v_pkg::STATUS_VALID;
      end
   end

endmodule
`default_nettype wire

@@ design/utf8v_top_core.sv @@
// Input register, scan state and result register of the UTF-8 text validator.
`default_nettype none
module utf8v_top_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [utf8v_pkg::DataWidth-1:0]    in_byte,
   input  logic                               in_last,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic                               out_is_utf8,
   output utf8v_pkg::status_type              out_status,
   output utf8v_pkg::scan_state_type          scan_state,
   output logic                               step_last
);

   logic                             s1_valid_ff, s1_valid_in;
   logic [utf8v_pkg::DataWidth-1:0]  s1_byte_ff;
   logic                             s1_last_ff;
   utf8v_pkg::scan_state_type        state_ff, state_in, state_next;
   utf8v_pkg::status_type            status_next;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             is_utf8_ff;
   utf8v_pkg::status_type            status_ff;
   logic                             advance;

   utf8v_decode u_decode (
      .cur_state  (state_ff),
      .data_byte  (s1_byte_ff),
      .next_state (state_next),
      .status     (status_next)
   );

   // A byte that ends no string never needs the result register.
   assign advance  = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || out_ready);
   assign in_ready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in  = in_ready ? in_valid : s1_valid_ff;
      rsp_valid_in = (rsp_valid_ff && !out_ready) || (advance && s1_last_ff);
      state_in     = state_ff;
      if (advance) begin
         state_in = s1_last_ff ? utf8v_pkg::ScanReset : state_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= utf8v_pkg::ScanReset;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         s1_byte_ff <= in_byte;
         s1_last_ff <= in_last;
      end
      if (advance && s1_last_ff) begin
         status_ff  <= status_next;
         is_utf8_ff <= (status_next == utf8v_pkg::STATUS_VALID);
      end
   end

   assign out_valid   = rsp_valid_ff;
   assign out_is_utf8 = is_utf8_ff;
   assign out_status  = status_ff;
   assign scan_state  = state_ff;
   assign step_last   = advance && s1_last_ff;

endmodule
`default_nettype wire

@@ design/utf8_text_validator_top.sv @@
// Top level of the UTF-8 text validator: stream ports and checks.
//
// The validator takes a string one byte per request and decides whether it is
// non-ASCII UTF-8 text under the old 1-to-6-byte lead forms (0xF8-0xFB, 0xFE
// and 0xFF count as 5-byte leads, 0xFC-0xFD as 6-byte leads). Each byte is a
// request on the req_ channel with req_tlast marking the final byte; only the
// final byte produces a response, carrying is_utf8 and a status code (valid,
// all ASCII, bad lead, bad continuation, truncated). The first failure in a
// string sticks and later bytes of that string are ignored; after the verdict
// the scan state returns to its reset value. The block sustains one byte per
// clock while no response stalls a final byte: each byte passes through an
// input register and one short decode step that updates the scan state, and
// the verdict of a final byte is written to a result register, which raises
// the response. A response waiting on rsp_tready holds the next final byte
// in the input register, and no further request is accepted until that
// response is taken; bytes that end no string keep flowing.
`default_nettype none
module utf8_text_validator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] is_utf8, [3:1] status, [7:4] zero
);

   logic                        is_utf8;
   utf8v_pkg::status_type       status;
   utf8v_pkg::scan_state_type   scan_state;
   logic                        step_last;

   utf8v_top_core u_core (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_byte     (req_tdata),
      .in_last     (req_tlast),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_is_utf8 (is_utf8),
      .out_status  (status),
      .scan_state  (scan_state),
      .step_last   (step_last)
   );

   assign rsp_tdata = {4'b0000, status, is_utf8};

   // The verdict flag agrees with the status code on every response.
   a_verdict_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (is_utf8 == (status == utf8v_pkg::STATUS_VALID)))
      else $error("is_utf8 disagrees with status");

   // Finishing a string leaves the scan state at its reset value.
   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      step_last |=> (scan_state == utf8v_pkg::ScanReset))
      else $error("scan state not cleared after a final byte");

   // A finished string always raises a response in the next cycle.
   a_response_raised: assert property (@(posedge clock) disable iff (reset)
      step_last |=> rsp_tvalid)
      else $error("final byte produced no response");

   // Pending count never exceeds the longest continuation run.
   a_pending_range: assert property (@(posedge clock) disable iff (reset)
      scan_state.pending <= 3'd5)
      else $error("pending continuation count out of range");

endmodule
`default_nettype wire
